>>> design/dd_pkg.sv
// Shared types and constants for the deadlock detector.
// Fixed field widths, operation codes and register map; no dependencies.
`default_nettype none

package dd_pkg;

  // Field widths of the item, result and register ports
  localparam int OP_W         = 2;
  localparam int PROC_IDX_W   = 3;
  localparam int RES_IDX_W    = 2;
  localparam int AMOUNT_W     = 8;
  localparam int MASK_W       = 8;
  localparam int PROC_COUNT_W = 4;
  localparam int RES_COUNT_W  = 3;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  // Register reset values
  localparam logic [PROC_COUNT_W-1:0] PROC_COUNT_RST = 4'd8;
  localparam logic [RES_COUNT_W-1:0]  RES_COUNT_RST  = 3'd4;

  // Register select, taken from paddr[2]
  localparam logic REG_PROC_COUNT = 1'b0;
  localparam logic REG_RES_COUNT  = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_AVAIL = 2'd0,
    OP_LOAD_ALLOC = 2'd1,
    OP_LOAD_REQ   = 2'd2,
    OP_RUN        = 2'd3
  } op_t;

endpackage

`default_nettype wire

>>> design/deadlock_detector.sv
// Multi-instance deadlock detector: table loads and a check run over them.
// Depends on dd_pkg (field widths, op codes, register map).
`default_nettype none

// Load items (available, allocation, request) give no result. A run item
// clears the finished marks and makes np passes over the np processes in use;
// each visit of an unfinished process reads its request row one column a cycle
// from the request memory and compares it with the available counts, and if it
// fits, reads its allocation row one column a cycle, adds it (saturating) into
// the available counts and zeroes both rows. A visit to a finished process only
// steps on. The length of a run is set by the single read port of each table
// memory. The run leaves the tables changed: reload before the next run.
// The allocation and request tables come up undefined and must be written
// before a run reads them. Items are not taken while a run is in progress;
// loads are taken while a run result still waits in the output register.
module deadlock_detector #(
  parameter int MAX_PROCS  = 8,
  parameter int MAX_RES    = 4,
  parameter int COUNT_BITS = 8
) (
  input  wire                                   clk,
  input  wire                                   rst,
  // item channel
  input  wire                                   cmd_valid,
  output logic                                  cmd_stall,
  input  wire  [dd_pkg::OP_W-1:0]               op,
  input  wire  [dd_pkg::PROC_IDX_W-1:0]         proc_index,
  input  wire  [dd_pkg::RES_IDX_W-1:0]          res_index,
  input  wire  [dd_pkg::AMOUNT_W-1:0]           amount,
  // result channel
  output logic                                  rslt_valid,
  input  wire                                   rslt_stall,
  output logic                                  deadlock,
  output logic [dd_pkg::MASK_W-1:0]             finished_mask,
  // configuration port
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire  [dd_pkg::PADDR_W-1:0]            paddr,
  input  wire  [dd_pkg::PDATA_W-1:0]            pwdata,
  output logic [dd_pkg::PDATA_W-1:0]            prdata,
  output logic                                  pready
);

  // Index widths; a single-entry dimension still gets one address bit
  localparam int PW        = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int RW        = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int NPW       = $clog2(MAX_PROCS + 1);
  localparam int NRW       = $clog2(MAX_RES + 1);
  localparam int AW        = COUNT_BITS + 4;
  localparam int MEM_DEPTH = MAX_PROCS << RW;
  localparam int MAW       = PW + RW;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_CHECK   = 4'b0010,
    S_RELEASE = 4'b0100,
    S_DONE    = 4'b1000
  } state_t;

  state_t state, state_next;

  // Configuration registers
  logic [dd_pkg::PROC_COUNT_W-1:0] proc_count;
  logic [dd_pkg::RES_COUNT_W-1:0]  res_count;

  // Run counters and read pipeline tag
  logic [NPW-1:0] pass_cnt, pass_next;
  logic [NPW-1:0] proc_cnt, proc_next;
  logic [NRW-1:0] ri, ri_next;
  logic [NRW-1:0] rd_r, rd_r_next;
  logic           rd_vld, rd_vld_next;

  logic [MAX_PROCS-1:0] finished, finished_next;
  logic [MAX_PROCS-1:0] used_mask;
  logic [AW-1:0]        avail [MAX_RES];

  // Table memories
  logic [COUNT_BITS-1:0] alloc_mem [MEM_DEPTH];
  logic [COUNT_BITS-1:0] req_mem   [MEM_DEPTH];
  logic [COUNT_BITS-1:0] alloc_q, req_q;
  logic                  alloc_rd, req_rd, alloc_we, req_we;
  logic [MAW-1:0]        rd_addr, wr_addr;
  logic [COUNT_BITS-1:0] wr_data;

  logic [NPW-1:0]        np;
  logic [NRW-1:0]        nr;
  logic [PW-1:0]         p_idx;
  logic [RW-1:0]         rd_idx;
  logic                  cmd_fire, cfg_wr, advance, release_col, rslt_load;
  logic                  ld_proc_ok, ld_res_ok;
  logic [COUNT_BITS-1:0] amt_c;
  logic [AW:0]           avail_sum;

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      proc_count <= dd_pkg::PROC_COUNT_RST;
      res_count  <= dd_pkg::RES_COUNT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == dd_pkg::REG_PROC_COUNT) begin
        proc_count <= pwdata[dd_pkg::PROC_COUNT_W-1:0];
      end else begin
        res_count <= pwdata[dd_pkg::RES_COUNT_W-1:0];
      end
    end
  end

  // Reads return the register at aligned addresses, zero elsewhere
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (paddr[2])
        dd_pkg::REG_PROC_COUNT: prdata = dd_pkg::PDATA_W'(proc_count);
        dd_pkg::REG_RES_COUNT:  prdata = dd_pkg::PDATA_W'(res_count);
        default:                prdata = '0;
      endcase
    end
  end

  // Counts in use, clamped to the table sizes
  always_comb begin
    if (32'(proc_count) > MAX_PROCS) begin
      np = NPW'(MAX_PROCS);
    end else begin
      np = NPW'(proc_count);
    end
    if (32'(res_count) > MAX_RES) begin
      nr = NRW'(MAX_RES);
    end else begin
      nr = NRW'(res_count);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_PROCS; i++) begin
      used_mask[i] = (i < int'(np));
    end
  end

  // ---------------------------------------------------------------------
  // Item decode
  // ---------------------------------------------------------------------
  assign cmd_stall  = (state != S_IDLE);
  assign cmd_fire   = cmd_valid && !cmd_stall;
  assign ld_proc_ok = (32'(proc_index) < MAX_PROCS);
  assign ld_res_ok  = (32'(res_index) < MAX_RES);
  assign amt_c      = COUNT_BITS'(amount);

  assign p_idx  = proc_cnt[PW-1:0];
  assign rd_idx = rd_r[RW-1:0];

  // ---------------------------------------------------------------------
  // Run sequencer: column reads issue every cycle, the compare or release
  // of a column happens in the cycle after, when its data returns.
  // ---------------------------------------------------------------------
  always_comb begin
    state_next    = state;
    pass_next     = pass_cnt;
    proc_next     = proc_cnt;
    ri_next       = ri;
    rd_r_next     = ri;
    rd_vld_next   = 1'b0;
    finished_next = finished;
    req_rd        = 1'b0;
    alloc_rd      = 1'b0;
    advance       = 1'b0;
    release_col   = 1'b0;

    case (state)
      S_IDLE: begin
        if (cmd_fire && op == dd_pkg::OP_RUN) begin
          finished_next = '0;
          pass_next     = '0;
          proc_next     = '0;
          ri_next       = '0;
          state_next    = (np == '0) ? S_DONE : S_CHECK;
        end
      end
      S_CHECK: begin
        if (finished[p_idx]) begin
          advance = 1'b1;
        end else if (nr == '0) begin
          // no resource types: every request fits, nothing to release
          finished_next[p_idx] = 1'b1;
          advance              = 1'b1;
        end else begin
          if (ri < nr) begin
            req_rd      = 1'b1;
            rd_vld_next = 1'b1;
            ri_next     = ri + NRW'(1);
          end
          if (rd_vld) begin
            if (AW'(req_q) > avail[rd_idx]) begin
              advance = 1'b1;
            end else if (rd_r == nr - NRW'(1)) begin
              state_next  = S_RELEASE;
              ri_next     = '0;
              rd_vld_next = 1'b0;
            end
          end
        end
      end
      S_RELEASE: begin
        if (ri < nr) begin
          alloc_rd    = 1'b1;
          rd_vld_next = 1'b1;
          ri_next     = ri + NRW'(1);
        end
        if (rd_vld) begin
          release_col = 1'b1;
          if (rd_r == nr - NRW'(1)) begin
            finished_next[p_idx] = 1'b1;
            advance              = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!rslt_valid || !rslt_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // Step to the next process, and to the next pass after the last one
    if (advance) begin
      ri_next     = '0;
      rd_vld_next = 1'b0;
      state_next  = S_CHECK;
      if (proc_cnt == np - NPW'(1)) begin
        proc_next = '0;
        if (pass_cnt == np - NPW'(1)) begin
          state_next = S_DONE;
        end else begin
          pass_next = pass_cnt + NPW'(1);
        end
      end else begin
        proc_next = proc_cnt + NPW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pass_cnt <= '0;
      proc_cnt <= '0;
      ri       <= '0;
      rd_vld   <= 1'b0;
      finished <= '0;
    end else begin
      state    <= state_next;
      pass_cnt <= pass_next;
      proc_cnt <= proc_next;
      ri       <= ri_next;
      rd_vld   <= rd_vld_next;
      finished <= finished_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= rd_r_next;
  end

  // ---------------------------------------------------------------------
  // Available counts: loads, and saturating release of an allocation
  // ---------------------------------------------------------------------
  assign avail_sum = {1'b0, avail[rd_idx]} + (AW + 1)'(alloc_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_RES; i++) begin
        avail[i] <= '0;
      end
    end else if (cmd_fire && op == dd_pkg::OP_LOAD_AVAIL && ld_res_ok) begin
      avail[RW'(res_index)] <= AW'(amt_c);
    end else if (release_col) begin
      avail[rd_idx] <= avail_sum[AW] ? {AW{1'b1}} : avail_sum[AW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Table memories: one read and one write port each. A released column is
  // zeroed one column behind the read, so the two never hit the same entry.
  // ---------------------------------------------------------------------
  assign rd_addr  = {p_idx, ri[RW-1:0]};
  assign wr_addr  = release_col ? {p_idx, rd_idx} : {PW'(proc_index), RW'(res_index)};
  assign wr_data  = release_col ? '0 : amt_c;
  assign alloc_we = release_col ||
                    (cmd_fire && op == dd_pkg::OP_LOAD_ALLOC && ld_proc_ok && ld_res_ok);
  assign req_we   = release_col ||
                    (cmd_fire && op == dd_pkg::OP_LOAD_REQ && ld_proc_ok && ld_res_ok);

  always_ff @(posedge clk) begin
    if (alloc_we) begin
      alloc_mem[wr_addr] <= wr_data;
    end
    if (alloc_rd) begin
      alloc_q <= alloc_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req_we) begin
      req_mem[wr_addr] <= wr_data;
    end
    if (req_rd) begin
      req_q <= req_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  assign rslt_load = (state == S_DONE) && (!rslt_valid || !rslt_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rslt_valid <= 1'b0;
    end else if (rslt_load) begin
      rslt_valid <= 1'b1;
    end else if (!rslt_stall) begin
      rslt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rslt_load) begin
      deadlock      <= ((finished & used_mask) != used_mask);
      finished_mask <= dd_pkg::MASK_W'(finished);
    end
  end

`ifndef ASSERT_OFF
  // A result appears only out of the end of a run
  a_rslt_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rslt_valid) |-> $past(state == S_DONE))
    else $error("result raised outside the end of a run");

  // A run never marks a process outside the count in use
  a_finished_in_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> ((finished & ~used_mask) == '0))
    else $error("finished mark outside the processes in use");

  // Returning read data always belongs to a column in use
  a_tag_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (rd_r < nr))
    else $error("read tag beyond the resource types in use");
`endif

endmodule

`default_nettype wire
